FILE: rtl/apde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apde_pkg
// Shared widths, register map and reset values of the annulus distance unit.
// ----------------------------------------------------------------------------
package apde_pkg;

    localparam int VALUE_BITS    = 8;
    localparam int HW_BITS       = 8;
    localparam int DIST_BITS     = 17;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;

    localparam logic [HW_BITS-1:0]   HW_RESET = 8'd10;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_CENTER_COL  = 3'd0,
        REG_CENTER_ROW  = 3'd1,
        REG_RADIUS      = 3'd2,
        REG_HALF_WIDTH  = 3'd3,
        REG_FOUND       = 3'd4
    } t_reg_idx;

endpackage

FILE: rtl/apde_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apde_pix_if
// Pixel beat channel: column, row and gray value with valid/ready.
// ----------------------------------------------------------------------------
interface apde_pix_if
    import apde_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [VALUE_BITS-1:0] pixel_value;

    modport source (output valid, pixel_col, pixel_row, pixel_value, input ready);
    modport sink   (input valid, pixel_col, pixel_row, pixel_value, output ready);
endinterface

FILE: rtl/apde_dist_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apde_dist_if
// Ring result channel: radial distance and gray value with valid/ready.
// ----------------------------------------------------------------------------
interface apde_dist_if
    import apde_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [DIST_BITS-1:0]  radial_distance;
    logic [VALUE_BITS-1:0] ring_value;

    modport source (output valid, radial_distance, ring_value, input ready);
    modport sink   (input valid, radial_distance, ring_value, output ready);
endinterface

FILE: rtl/apde_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apde_cfg_regs
// APB register file holding the circle geometry and the enable.
// ----------------------------------------------------------------------------
module apde_cfg_regs
    import apde_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic [COORD_BITS-1:0]    o_center_col,
    output logic [COORD_BITS-1:0]    o_center_row,
    output logic [COORD_BITS-1:0]    o_radius,
    output logic [HW_BITS-1:0]       o_half_width,
    output logic                     o_found
);

    logic [COORD_BITS-1:0] r_center_col;
    logic [COORD_BITS-1:0] r_center_row;
    logic [COORD_BITS-1:0] r_radius;
    logic [HW_BITS-1:0]    r_half_width;
    logic                  r_found;
    logic                  wr_en;
    t_reg_idx              idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_col <= '0;
            r_center_row <= '0;
            r_radius     <= '0;
            r_half_width <= HW_RESET;
            r_found      <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_CENTER_COL: r_center_col <= pwdata[COORD_BITS-1:0];
                REG_CENTER_ROW: r_center_row <= pwdata[COORD_BITS-1:0];
                REG_RADIUS:     r_radius     <= pwdata[COORD_BITS-1:0];
                REG_HALF_WIDTH: r_half_width <= pwdata[HW_BITS-1:0];
                REG_FOUND:      r_found      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CENTER_COL: prdata = APB_DATA_BITS'(r_center_col);
            REG_CENTER_ROW: prdata = APB_DATA_BITS'(r_center_row);
            REG_RADIUS:     prdata = APB_DATA_BITS'(r_radius);
            REG_HALF_WIDTH: prdata = APB_DATA_BITS'(r_half_width);
            REG_FOUND:      prdata = APB_DATA_BITS'(r_found);
            default:        prdata = '0;
        endcase
    end

    assign o_center_col = r_center_col;
    assign o_center_row = r_center_row;
    assign o_radius     = r_radius;
    assign o_half_width = r_half_width;
    assign o_found      = r_found;

endmodule

FILE: rtl/apde_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apde_front
// Three stages: offsets, squares, then squared distance against the ring.
// ----------------------------------------------------------------------------
module apde_front
    import apde_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [COORD_BITS-1:0]   i_center_col,
    input  logic [COORD_BITS-1:0]   i_center_row,
    input  logic [COORD_BITS-1:0]   i_radius,
    input  logic [HW_BITS-1:0]      i_half_width,
    input  logic                    i_found,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [COORD_BITS-1:0]   i_col,
    input  logic [COORD_BITS-1:0]   i_row,
    input  logic [VALUE_BITS-1:0]   i_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [2*COORD_BITS:0]   o_d2,
    output logic [VALUE_BITS-1:0]   o_value
);

    localparam int SQ_BITS = 2 * COORD_BITS;
    localparam int D2_BITS = SQ_BITS + 1;
    localparam int RO_BITS = COORD_BITS + 1;

    logic s1_rdy, s2_rdy, s3_rdy;

    // stage 1: absolute offsets and ring radii
    logic                  r_s1_valid;
    logic [COORD_BITS-1:0] r_s1_dx, r_s1_dy, r_s1_ri;
    logic [RO_BITS-1:0]    r_s1_ro;
    logic [VALUE_BITS-1:0] r_s1_value;
    logic [COORD_BITS-1:0] n_s1_dx, n_s1_dy, n_s1_ri;
    logic [RO_BITS-1:0]    n_s1_ro;

    // stage 2: squares
    logic                  r_s2_valid;
    logic [SQ_BITS-1:0]    r_s2_sqx, r_s2_sqy, r_s2_ri2;
    logic [2*RO_BITS-1:0]  r_s2_ro2;
    logic [VALUE_BITS-1:0] r_s2_value;

    // stage 3: ring test, drop pixels outside
    logic                  r_s3_valid;
    logic [D2_BITS-1:0]    r_s3_d2;
    logic [VALUE_BITS-1:0] r_s3_value;
    logic [D2_BITS-1:0]    n_s3_d2;
    logic                  n_s3_keep;

    assign s3_rdy  = !r_s3_valid || i_ready;
    assign s2_rdy  = !r_s2_valid || s3_rdy;
    assign s1_rdy  = !r_s1_valid || s2_rdy;
    assign o_ready = s1_rdy;

    always_comb begin
        n_s1_dx = (i_col >= i_center_col) ? i_col - i_center_col : i_center_col - i_col;
        n_s1_dy = (i_row >= i_center_row) ? i_row - i_center_row : i_center_row - i_row;
        n_s1_ro = RO_BITS'(i_radius) + RO_BITS'(i_half_width);
        // clamp the inner radius at zero
        n_s1_ri = (i_radius > COORD_BITS'(i_half_width))
                  ? i_radius - COORD_BITS'(i_half_width) : '0;
    end

    always_comb begin
        n_s3_d2   = D2_BITS'(r_s2_sqx) + D2_BITS'(r_s2_sqy);
        n_s3_keep = ((D2_BITS+1)'(n_s3_d2) <= (D2_BITS+1)'(r_s2_ro2))
                    && (n_s3_d2 >= D2_BITS'(r_s2_ri2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (s1_rdy) r_s1_valid <= i_valid && i_found;
            if (s2_rdy) r_s2_valid <= r_s1_valid;
            if (s3_rdy) r_s3_valid <= r_s2_valid && n_s3_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_dx    <= n_s1_dx;
            r_s1_dy    <= n_s1_dy;
            r_s1_ri    <= n_s1_ri;
            r_s1_ro    <= n_s1_ro;
            r_s1_value <= i_value;
        end
        if (s2_rdy) begin
            r_s2_sqx   <= SQ_BITS'(r_s1_dx) * SQ_BITS'(r_s1_dx);
            r_s2_sqy   <= SQ_BITS'(r_s1_dy) * SQ_BITS'(r_s1_dy);
            r_s2_ri2   <= SQ_BITS'(r_s1_ri) * SQ_BITS'(r_s1_ri);
            r_s2_ro2   <= (2*RO_BITS)'(r_s1_ro) * (2*RO_BITS)'(r_s1_ro);
            r_s2_value <= r_s1_value;
        end
        if (s3_rdy) begin
            r_s3_d2    <= n_s3_d2;
            r_s3_value <= r_s2_value;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_d2    = r_s3_d2;
    assign o_value = r_s3_value;

endmodule

FILE: rtl/apde_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apde_isqrt
// Pipelined restoring square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module apde_isqrt
    import apde_pkg::*;
#(
    parameter int ROOT_BITS = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2*ROOT_BITS-1:0] i_radicand,
    input  logic [VALUE_BITS-1:0]  i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [ROOT_BITS-1:0]   o_root,
    output logic [VALUE_BITS-1:0]  o_value
);

    localparam int RAD_BITS = 2 * ROOT_BITS;
    localparam int REM_BITS = ROOT_BITS + 2;

    logic                  r_valid [ROOT_BITS];
    logic [REM_BITS-1:0]   r_rem   [ROOT_BITS];
    logic [ROOT_BITS-1:0]  r_root  [ROOT_BITS];
    logic [RAD_BITS-1:0]   r_rad   [ROOT_BITS];
    logic [VALUE_BITS-1:0] r_value [ROOT_BITS];
    logic                  stg_rdy [ROOT_BITS+1];

    assign stg_rdy[ROOT_BITS] = i_ready;

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        logic                  p_valid;
        logic [REM_BITS-1:0]   p_rem;
        logic [ROOT_BITS-1:0]  p_root;
        logic [RAD_BITS-1:0]   p_rad;
        logic [VALUE_BITS-1:0] p_value;
        logic [REM_BITS-1:0]   rem_sh;
        logic [REM_BITS-1:0]   trial;
        logic [REM_BITS-1:0]   n_rem;
        logic [ROOT_BITS-1:0]  n_root;

        if (k == 0) begin : g_head
            assign p_valid = i_valid;
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_rad   = i_radicand;
            assign p_value = i_value;
        end else begin : g_body
            assign p_valid = r_valid[k-1];
            assign p_rem   = r_rem[k-1];
            assign p_root  = r_root[k-1];
            assign p_rad   = r_rad[k-1];
            assign p_value = r_value[k-1];
        end

        assign stg_rdy[k] = !r_valid[k] || stg_rdy[k+1];

        // bring down the next two radicand bits, try root*4+1
        always_comb begin
            rem_sh = {p_rem[ROOT_BITS-1:0], p_rad[RAD_BITS-1-2*k -: 2]};
            trial  = {p_root, 2'b01};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {p_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {p_root[ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (stg_rdy[k]) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (stg_rdy[k]) begin
                r_rem[k]   <= n_rem;
                r_root[k]  <= n_root;
                r_rad[k]   <= p_rad;
                r_value[k] <= p_value;
            end
        end
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = r_valid[ROOT_BITS-1];
    assign o_root  = r_root[ROOT_BITS-1];
    assign o_value = r_value[ROOT_BITS-1];

endmodule

FILE: rtl/annulus_pixel_distance_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annulus_pixel_distance_extractor_unit
// Annular region-of-interest filter emitting gray value and radial distance.
// ----------------------------------------------------------------------------
// Each pixel beat (column, row, gray value) is tested against a ring around
// the configured circle center: squared distance between the squared inner
// radius max(radius - half_width, 0) and the squared outer radius
// (radius + half_width), bounds inclusive. A pixel in the ring yields one
// result beat carrying its gray value and floor(sqrt(d2) * 2^DIST_FRAC_BITS),
// saturated at the 17-bit field; any other pixel, and every pixel while
// circle_found is 0, yields nothing. The unit takes one pixel per clock
// unless result back-pressure has filled the pipeline. A pixel passes
// through three front stages (offsets, squares, ring test), one
// square-root stage per root bit, and the output register.
// Registers (APB, byte address 4*index): center_col, center_row,
// circle_radius, ring_half_width, circle_found. Write them only while no
// pixel is in flight. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module annulus_pixel_distance_extractor_unit
    import apde_pkg::*;
#(
    parameter int COORD_BITS     = 12,
    parameter int DIST_FRAC_BITS = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    apde_pix_if.sink                 i_pix,
    apde_dist_if.source              o_dist,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int D2_BITS   = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS = COORD_BITS + 1 + DIST_FRAC_BITS;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int SAT_BITS  = (ROOT_BITS > DIST_BITS) ? ROOT_BITS : DIST_BITS;

    // configuration
    logic [COORD_BITS-1:0] cfg_center_col;
    logic [COORD_BITS-1:0] cfg_center_row;
    logic [COORD_BITS-1:0] cfg_radius;
    logic [HW_BITS-1:0]    cfg_half_width;
    logic                  cfg_found;

    // front to root pipeline
    logic                  fr_valid;
    logic                  fr_ready;
    logic [D2_BITS-1:0]    fr_d2;
    logic [VALUE_BITS-1:0] fr_value;
    logic [RAD_BITS-1:0]   fr_radicand;

    // root pipeline to output register
    logic                  sq_valid;
    logic                  sq_ready;
    logic [ROOT_BITS-1:0]  sq_root;
    logic [VALUE_BITS-1:0] sq_value;
    logic [SAT_BITS-1:0]   sq_root_ext;
    logic [DIST_BITS-1:0]  n_out_dist;

    // output register
    logic                  r_out_valid;
    logic [DIST_BITS-1:0]  r_out_dist;
    logic [VALUE_BITS-1:0] r_out_value;

    assign pready = 1'b1;

    apde_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .o_center_col (cfg_center_col),
        .o_center_row (cfg_center_row),
        .o_radius     (cfg_radius),
        .o_half_width (cfg_half_width),
        .o_found      (cfg_found)
    );

    // offsets, squares and ring test; pixels outside the ring become bubbles
    apde_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_center_col (cfg_center_col),
        .i_center_row (cfg_center_row),
        .i_radius     (cfg_radius),
        .i_half_width (cfg_half_width),
        .i_found      (cfg_found),
        .i_valid      (i_pix.valid),
        .o_ready      (i_pix.ready),
        .i_col        (i_pix.pixel_col),
        .i_row        (i_pix.pixel_row),
        .i_value      (i_pix.pixel_value),
        .o_valid      (fr_valid),
        .i_ready      (fr_ready),
        .o_d2         (fr_d2),
        .o_value      (fr_value)
    );

    // scale by 4^frac so the integer root carries the fraction bits
    assign fr_radicand = RAD_BITS'(fr_d2) << (2 * DIST_FRAC_BITS);

    apde_isqrt #(
        .ROOT_BITS (ROOT_BITS)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (fr_valid),
        .o_ready    (fr_ready),
        .i_radicand (fr_radicand),
        .i_value    (fr_value),
        .o_valid    (sq_valid),
        .i_ready    (sq_ready),
        .o_root     (sq_root),
        .o_value    (sq_value)
    );

    // saturate the root into the distance field
    always_comb begin
        sq_root_ext = SAT_BITS'(sq_root);
        if (sq_root_ext > SAT_BITS'(DIST_MAX)) begin
            n_out_dist = DIST_MAX;
        end else begin
            n_out_dist = sq_root_ext[DIST_BITS-1:0];
        end
    end

    // output register: load when empty or when the held beat leaves
    assign sq_ready = !r_out_valid || o_dist.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (sq_ready) begin
            r_out_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sq_ready) begin
            r_out_dist  <= n_out_dist;
            r_out_value <= sq_value;
        end
    end

    assign o_dist.valid           = r_out_valid;
    assign o_dist.radial_distance = r_out_dist;
    assign o_dist.ring_value      = r_out_value;

    // a finished root must hold while the output beat is stalled
    a_root_held_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_valid && r_out_valid && !o_dist.ready |=> sq_valid && $stable(sq_root))
        else $error("root pipeline advanced while output was stalled");

    // the output register only fills from a valid root beat
    a_out_from_root : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(sq_valid))
        else $error("output beat appeared without a root beat");

    // reset empties the output register
    a_reset_empties : assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid after reset");

endmodule

FILE: dv/annulus_pixel_distance_extractor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annulus_pixel_distance_extractor_unit_tb
// Self-checking bench for the annular ring pixel filter and distance unit.
// ----------------------------------------------------------------------------
// Pixel beats go in through the valid/ready pixel channel. A shadow copy of
// the ring registers predicts, at every accepted pixel beat, whether a result
// beat is due and what radial distance and gray value it must carry. A
// monitor on the result channel compares each result beat with the oldest
// prediction. Register writes go over APB only while the unit is drained.
// Directed tests hit the ring bounds, coordinate extremes, degenerate rings,
// the disabled state and unknown register addresses; random phases then
// sweep ring settings with pixels aimed at the ring, plus a long receiver
// hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module annulus_pixel_distance_extractor_unit_tb;
    import apde_pkg::*;

    localparam int COORD_BITS     = 12;
    localparam int DIST_FRAC_BITS = 4;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    // accept-to-result latency of the unit pipeline
    localparam int PIPE_LATENCY   = 4 + COORD_BITS + 1 + DIST_FRAC_BITS;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 16;
    localparam int LONG_HOLD      = 300;
    localparam int STALL_LIMIT    = 5000;

    // addresses with no register behind them
    localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [DIST_BITS-1:0]  radial_distance;
        logic [VALUE_BITS-1:0] ring_value;
    } ring_beat_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    apde_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();
    apde_dist_if                           dist_ch ();

    annulus_pixel_distance_extractor_unit #(
        .COORD_BITS     (COORD_BITS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_dist  (dist_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the ring registers, as the unit should hold them
    logic [COORD_BITS-1:0] cfg_center_col;
    logic [COORD_BITS-1:0] cfg_center_row;
    logic [COORD_BITS-1:0] cfg_radius;
    logic [HW_BITS-1:0]    cfg_half_width;
    logic                  cfg_found;

    ring_beat_t expected_ring_q[$];

    int unsigned mismatch_count;
    int unsigned pixels_sent;
    int unsigned ring_beats_seen;
    int unsigned reg_writes;
    int unsigned ring_settings;

    // Idling controls shared by the sender, the receiver and the tests
    bit src_idle_en;
    bit snk_idle_en;
    bit snk_drain;
    bit snk_long_hold_req;

    // ------------------------------------------------------------------------
    // Ring prediction
    // ------------------------------------------------------------------------

    // Floor of the square root, one result bit at a time from the top.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v) begin
                root = cand;
            end
        end
        return root;
    endfunction

    // Decide ring membership and build the result beat a pixel must cause.
    function automatic bit predict_ring_beat(
        input  logic [COORD_BITS-1:0] col,
        input  logic [COORD_BITS-1:0] row,
        input  logic [VALUE_BITS-1:0] value,
        output ring_beat_t            beat
    );
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned d2;
        longint unsigned outer_r;
        longint unsigned inner_r;
        longint unsigned scaled_root;
        beat = '0;
        if (!cfg_found) begin
            return 1'b0;
        end
        dx = (col >= cfg_center_col) ? longint'(col - cfg_center_col)
                                     : longint'(cfg_center_col - col);
        dy = (row >= cfg_center_row) ? longint'(row - cfg_center_row)
                                     : longint'(cfg_center_row - row);
        d2 = dx * dx + dy * dy;
        outer_r = longint'(cfg_radius) + longint'(cfg_half_width);
        // clamp the inner radius at zero when the half width is larger
        inner_r = (cfg_radius > cfg_half_width)
                ? longint'(cfg_radius) - longint'(cfg_half_width) : 0;
        if (d2 > outer_r * outer_r || d2 < inner_r * inner_r) begin
            return 1'b0;
        end
        scaled_root = floor_sqrt(d2 << (2 * DIST_FRAC_BITS));
        if (scaled_root > longint'(DIST_MAX)) begin
            scaled_root = longint'(DIST_MAX);
        end
        beat.radial_distance = scaled_root[DIST_BITS-1:0];
        beat.ring_value      = value;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // mirror the write, masked to each register's width
        case (idx)
            REG_CENTER_COL: cfg_center_col = data[COORD_BITS-1:0];
            REG_CENTER_ROW: cfg_center_row = data[COORD_BITS-1:0];
            REG_RADIUS:     cfg_radius     = data[COORD_BITS-1:0];
            REG_HALF_WIDTH: cfg_half_width = data[HW_BITS-1:0];
            REG_FOUND:      cfg_found      = data[0];
            default:        ;
        endcase
        reg_writes++;
        // return to idle so back-to-back transfers do not collide
        @(posedge i_clk);
    endtask

    task automatic check_reg_readback(input logic [2:0] idx);
        logic [31:0] want;
        logic [31:0] got;
        case (idx)
            REG_CENTER_COL: want = 32'(cfg_center_col);
            REG_CENTER_ROW: want = 32'(cfg_center_row);
            REG_RADIUS:     want = 32'(cfg_radius);
            REG_HALF_WIDTH: want = 32'(cfg_half_width);
            default:        want = 32'(cfg_found);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            $error("prdata mismatch at index %0d: expected %0d, actual %0d",
                   idx, want, got);
            mismatch_count++;
        end
        @(posedge i_clk);
    endtask

    // Drop valid, wait for every predicted beat, then let the pipe empty of
    // pixels that cause no result before any register is touched.
    task automatic wait_quiet();
        pix_ch.valid <= 1'b0;
        while (expected_ring_q.size() != 0) begin
            @(posedge i_clk);
        end
        snk_drain = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        snk_drain = 1'b0;
    endtask

    // Load a complete ring setting; junk in the upper data bits must be masked.
    task automatic set_ring(
        input int cc, input int cr, input int radius, input int hw, input bit found
    );
        wait_quiet();
        write_reg(REG_CENTER_COL, {$urandom_range(0, 1) ? 20'hFFFFF : 20'h0,
                                   12'(cc)});
        write_reg(REG_CENTER_ROW, {$urandom_range(0, 1) ? 20'hFFFFF : 20'h0,
                                   12'(cr)});
        write_reg(REG_RADIUS,     {20'($urandom), 12'(radius)});
        write_reg(REG_HALF_WIDTH, {24'($urandom), 8'(hw)});
        write_reg(REG_FOUND,      {31'($urandom), found});
        ring_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Pixel sender
    // ------------------------------------------------------------------------

    task automatic send_pixel(
        input logic [COORD_BITS-1:0] col,
        input logic [COORD_BITS-1:0] row,
        input logic [VALUE_BITS-1:0] value
    );
        ring_beat_t beat;
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_col   <= col;
        pix_ch.pixel_row   <= row;
        pix_ch.pixel_value <= value;
        do @(posedge i_clk); while (!pix_ch.ready);
        // beat accepted at this edge
        pixels_sent++;
        if (predict_ring_beat(col, row, value, beat)) begin
            expected_ring_q = {expected_ring_q, beat};
        end
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Aim at a radius just around the ring band, then clamp into the image.
    task automatic send_ring_pixel();
        int inner_r;
        int outer_r;
        int r;
        int dx;
        int dy;
        int c;
        int w;
        inner_r = (cfg_radius > cfg_half_width) ? int'(cfg_radius) - int'(cfg_half_width)
                                                : 0;
        outer_r = int'(cfg_radius) + int'(cfg_half_width);
        r  = $urandom_range(inner_r > 0 ? inner_r - 1 : 0, outer_r + 1);
        dx = $urandom_range(0, r);
        dy = int'(floor_sqrt(longint'(r * r - dx * dx))) + $urandom_range(0, 1);
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        c = int'(cfg_center_col) + dx;
        w = int'(cfg_center_row) + dy;
        c = (c < 0) ? 0 : (c > COORD_MAX) ? COORD_MAX : c;
        w = (w < 0) ? 0 : (w > COORD_MAX) ? COORD_MAX : w;
        send_pixel(COORD_BITS'(c), COORD_BITS'(w), VALUE_BITS'($urandom));
    endtask

    // Mostly ring-aimed pixels, with full-range noise mixed in.
    task automatic send_random_pixel();
        if ($urandom_range(0, 3) == 0) begin
            send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom),
                       VALUE_BITS'($urandom));
        end else begin
            send_ring_pixel();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: random ready, drain mode, and one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        dist_ch.ready <= 1'b0;
        forever begin
            if (snk_long_hold_req) begin
                snk_long_hold_req = 1'b0;
                dist_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (snk_drain || !snk_idle_en) begin
                dist_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                dist_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else if ($urandom_range(0, 9) == 0) begin
                // a stretch with no stall at all
                dist_ch.ready <= 1'b1;
                repeat ($urandom_range(40, 80)) @(posedge i_clk);
            end else begin
                dist_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each beat with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        ring_beat_t want;
        if (i_rst_n === 1'b1 && dist_ch.valid && dist_ch.ready) begin
            ring_beats_seen++;
            if (expected_ring_q.size() == 0) begin
                $error("unexpected result beat: radial_distance %0d, ring_value %0d",
                       dist_ch.radial_distance, dist_ch.ring_value);
                mismatch_count++;
            end else begin
                want = expected_ring_q.pop_front();
                if (dist_ch.radial_distance !== want.radial_distance) begin
                    $error("radial_distance mismatch: expected %0d, actual %0d",
                           want.radial_distance, dist_ch.radial_distance);
                    mismatch_count++;
                end
                if (dist_ch.ring_value !== want.ring_value) begin
                    $error("ring_value mismatch: expected %0d, actual %0d",
                           want.ring_value, dist_ch.ring_value);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no beat or transfer moves for too long
    // ------------------------------------------------------------------------
    int unsigned stall_cycles;
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (dist_ch.valid && dist_ch.ready) ||
            (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values read back, and a disabled unit passes nothing.
    task automatic test_reset_state();
        for (int i = REG_CENTER_COL; i <= REG_FOUND; i++) begin
            check_reg_readback(3'(i));
        end
        send_pixel('0, '0, 8'hFF);
        send_pixel(COORD_BITS'(10), '0, 8'h00);
    endtask

    // Every register written with junk above its width; unmapped writes ignored.
    task automatic test_register_access();
        set_ring(1234, 3210, 345, 67, 1'b1);
        for (int i = REG_CENTER_COL; i <= REG_FOUND; i++) begin
            check_reg_readback(3'(i));
        end
        for (int i = REG_UNMAPPED_LO; i <= REG_UNMAPPED_HI; i++) begin
            write_reg(3'(i), $urandom);
        end
        for (int i = REG_CENTER_COL; i <= REG_FOUND; i++) begin
            check_reg_readback(3'(i));
        end
        // still the same ring after the ignored writes
        send_pixel(COORD_BITS'(1234 + 345), COORD_BITS'(3210), 8'h5A);
        send_pixel(COORD_BITS'(1234), COORD_BITS'(3210 - 345 - 67), 8'hA5);
    endtask

    // Inner and outer bounds are inclusive: hit them exactly and miss by one.
    task automatic test_ring_bounds();
        set_ring(100, 200, 50, 10, 1'b1);
        send_pixel(COORD_BITS'(100), COORD_BITS'(200), 8'h11);
        send_pixel(COORD_BITS'(160), COORD_BITS'(200), 8'hFF);
        send_pixel(COORD_BITS'(161), COORD_BITS'(200), 8'h22);
        send_pixel(COORD_BITS'(140), COORD_BITS'(200), 8'h00);
        send_pixel(COORD_BITS'(139), COORD_BITS'(200), 8'h33);
        send_pixel(COORD_BITS'(100), COORD_BITS'(260), 8'h44);
        send_pixel(COORD_BITS'(136), COORD_BITS'(248), 8'h80);
        send_pixel(COORD_BITS'(137), COORD_BITS'(248), 8'h7F);
        send_pixel(COORD_BITS'(70),  COORD_BITS'(160), 8'h01);
    endtask

    // Corner pixels against a ring of the largest radius and half width.
    task automatic test_coordinate_extremes();
        set_ring(0, 0, COORD_MAX, 255, 1'b1);
        send_pixel(COORD_BITS'(COORD_MAX), '0, 8'hFF);
        send_pixel('0, COORD_BITS'(COORD_MAX), 8'h00);
        send_pixel(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 8'hC3);
        send_pixel('0, '0, 8'h3C);
        set_ring(COORD_MAX, COORD_MAX, COORD_MAX, 255, 1'b1);
        send_pixel('0, COORD_BITS'(COORD_MAX), 8'hAA);
        send_pixel(COORD_BITS'(COORD_MAX), '0, 8'h55);
        send_pixel('0, '0, 8'h99);
    endtask

    // Zero-size ring keeps only the center; a wide ring clamps its inner edge.
    task automatic test_degenerate_rings();
        set_ring(2048, 2048, 0, 0, 1'b1);
        send_pixel(COORD_BITS'(2048), COORD_BITS'(2048), 8'hE7);
        send_pixel(COORD_BITS'(2049), COORD_BITS'(2048), 8'h18);
        set_ring(7, 9, 5, 20, 1'b1);
        send_pixel(COORD_BITS'(7),  COORD_BITS'(9), 8'h42);
        send_pixel('0, '0, 8'h24);
        send_pixel(COORD_BITS'(32), COORD_BITS'(9), 8'h81);
        send_pixel(COORD_BITS'(33), COORD_BITS'(9), 8'h7E);
    endtask

    // No circle found: even in-ring pixels must produce nothing.
    task automatic test_circle_not_found();
        set_ring(500, 600, 100, 5, 1'b0);
        send_pixel(COORD_BITS'(600), COORD_BITS'(600), 8'hFF);
        send_pixel(COORD_BITS'(500), COORD_BITS'(700), 8'h01);
        repeat (8) send_ring_pixel();
    endtask

    // Sweep ring settings, the extremes first, with ring-aimed pixels.
    task automatic test_random_rings();
        for (int p = 0; p < 15; p++) begin
            case (p)
                0:       set_ring(0, 0, COORD_MAX, 255, 1'b1);
                1:       set_ring(COORD_MAX, COORD_MAX, COORD_MAX, 255, 1'b1);
                2:       set_ring(2048, 2048, 0, 0, 1'b1);
                3:       set_ring(2048, 2048, 3, 255, 1'b1);
                4:       set_ring(0, COORD_MAX, COORD_MAX, 0, 1'b1);
                default: set_ring($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                  $urandom_range(0, COORD_MAX), $urandom_range(0, 255),
                                  1'b1);
            endcase
            repeat (55) send_random_pixel();
        end
    endtask

    // Hold off the receiver while the sender keeps offering ring pixels.
    task automatic test_backpressure();
        set_ring(2048, 2048, 100, 20, 1'b1);
        src_idle_en = 1'b0;
        snk_long_hold_req = 1'b1;
        // start offering only once the receiver has entered its hold-off
        wait (!snk_long_hold_req);
        repeat (80) send_ring_pixel();
        src_idle_en = 1'b1;
    endtask

    // Final stretch: no idling on either side.
    task automatic test_full_rate();
        set_ring($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(1, 600), $urandom_range(0, 255), 1'b1);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        repeat (150) send_random_pixel();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel_col   <= '0;
        pix_ch.pixel_row   <= '0;
        pix_ch.pixel_value <= '0;
        cfg_center_col  = '0;
        cfg_center_row  = '0;
        cfg_radius      = '0;
        cfg_half_width  = HW_RESET;
        cfg_found       = 1'b0;
        mismatch_count  = 0;
        pixels_sent     = 0;
        ring_beats_seen = 0;
        reg_writes      = 0;
        ring_settings   = 0;
        src_idle_en     = 1'b1;
        snk_idle_en     = 1'b1;
        snk_drain       = 1'b0;
        snk_long_hold_req = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_register_access();
        test_ring_bounds();
        test_coordinate_extremes();
        test_degenerate_rings();
        test_circle_not_found();
        test_random_rings();
        test_backpressure();
        test_full_rate();

        // drain: every prediction met, then let stragglers show up
        pix_ch.valid <= 1'b0;
        while (expected_ring_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_ring_q.size() != 0) begin
            $error("%0d predicted result beats never arrived", expected_ring_q.size());
            mismatch_count++;
        end

        $display("Sent %0d pixel beats over %0d ring settings with %0d register writes;",
                 pixels_sent, ring_settings, reg_writes);
        $display("checked %0d ring result beats, %0d mismatches.",
                 ring_beats_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/apde_pkg.sv
rtl/apde_pix_if.sv
rtl/apde_dist_if.sv
rtl/apde_cfg_regs.sv
rtl/apde_front.sv
rtl/apde_isqrt.sv
rtl/annulus_pixel_distance_extractor_unit.sv
dv/annulus_pixel_distance_extractor_unit_tb.sv
